>>> design/dqrp_pkg.sv
// Shared types and constants for the DNS question and record parser.
`default_nettype none
package dqrp_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [7:0]  DOT_CHAR     = 8'd46;
  localparam logic [3:0]  QFIELD_BYTES = 4'd4;
  localparam logic [3:0]  TTL_END      = 4'd8;
  localparam logic [3:0]  LEN_END      = 4'd10;
  localparam logic [3:0]  RFIELD_BYTES = 4'd14;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_QFIELDS = 3'd2,
    PH_RFIELDS = 3'd3,
    PH_IDLE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_QUESTION = 2'd1,
    KIND_RECORD   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        message_start;
    logic [15:0] question_count;
    logic [15:0] record_count;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [15:0] rr_type;
    logic [15:0] rr_class;
    logic [31:0] time_to_live;
    logic [15:0] data_length;
    logic [31:0] record_data;
    logic        message_done;
  } result_t;

endpackage
`default_nettype wire

>>> design/dqrp_in_stage.sv
// Input register holding one accepted byte item until the parser takes it.
`default_nettype none
module dqrp_in_stage
  import dqrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t item_in,
  input  wire logic  advance,
  output logic       stage_valid,
  output item_t      stage_item
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= item_in;
    end
  end

endmodule
`default_nettype wire

>>> design/dqrp_step.sv
// Parse state registers and the per-byte next-state and result logic.
`default_nettype none
module dqrp_step
  import dqrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  advance,
  output logic       has_result,
  output result_t    result
);

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  header_bytes_seen, header_bytes_seen_next;
  logic [7:0]  label_bytes_left, label_bytes_left_next;
  logic        first_label_flag, first_label_flag_next;
  logic [3:0]  field_byte_index, field_byte_index_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] records_left, records_left_next;
  logic [31:0] type_class_shift, type_class_shift_next;
  logic [31:0] ttl_shift, ttl_shift_next;
  logic [15:0] length_shift, length_shift_next;
  logic [31:0] data_shift, data_shift_next;

  logic [7:0]  b;
  logic [3:0]  idx_inc;
  logic        start_now;
  logic        done;

  assign b = item.data_byte;

  always_comb begin
    parse_phase_next       = parse_phase;
    header_bytes_seen_next = header_bytes_seen;
    label_bytes_left_next  = label_bytes_left;
    first_label_flag_next  = first_label_flag;
    field_byte_index_next  = field_byte_index;
    questions_left_next    = questions_left;
    records_left_next      = records_left;
    type_class_shift_next  = type_class_shift;
    ttl_shift_next         = ttl_shift;
    length_shift_next      = length_shift;
    data_shift_next        = data_shift;
    has_result             = 1'b0;
    result                 = '0;
    start_now              = 1'b0;
    done                   = 1'b0;
    idx_inc                = field_byte_index + 4'd1;

    if (item.message_start) begin
      questions_left_next    = item.question_count;
      records_left_next      = item.record_count;
      header_bytes_seen_next = '0;
      if (HEADER_BYTES == 0) begin
        label_bytes_left_next = '0;
        first_label_flag_next = 1'b1;
        field_byte_index_next = '0;
        type_class_shift_next = '0;
        ttl_shift_next        = '0;
        length_shift_next     = '0;
        data_shift_next       = '0;
        parse_phase_next = ((item.question_count != '0) || (item.record_count != '0)) ?
                           PH_NAME : PH_IDLE;
      end else begin
        parse_phase_next = PH_HEADER;
      end
    end

    idx_inc = field_byte_index_next + 4'd1;

    unique case (parse_phase_next)
      PH_HEADER: begin
        header_bytes_seen_next = header_bytes_seen_next + 4'd1;
        if (header_bytes_seen_next >= HEADER_BYTES[3:0]) begin
          start_now = 1'b1;
        end
      end
      PH_NAME: begin
        if (label_bytes_left_next != '0) begin
          label_bytes_left_next = label_bytes_left_next - 8'd1;
          has_result            = 1'b1;
          result.kind           = KIND_CHAR;
          result.name_char      = b;
        end else if (b == '0) begin
          field_byte_index_next = '0;
          parse_phase_next = (questions_left_next != '0) ? PH_QFIELDS : PH_RFIELDS;
        end else begin
          label_bytes_left_next = b;
          if (first_label_flag_next) begin
            first_label_flag_next = 1'b0;
          end else begin
            has_result       = 1'b1;
            result.kind      = KIND_CHAR;
            result.name_char = DOT_CHAR;
          end
        end
      end
      PH_QFIELDS: begin
        type_class_shift_next = {type_class_shift_next[23:0], b};
        field_byte_index_next = idx_inc;
        if (idx_inc >= QFIELD_BYTES) begin
          questions_left_next = questions_left_next - 16'd1;
          done = (questions_left_next == '0) && (records_left_next == '0);
          has_result          = 1'b1;
          result.kind         = KIND_QUESTION;
          result.rr_type      = type_class_shift_next[31:16];
          result.rr_class     = type_class_shift_next[15:0];
          result.message_done = done;
          start_now           = 1'b1;
        end
      end
      PH_RFIELDS: begin
        priority if (field_byte_index_next < QFIELD_BYTES) begin
          type_class_shift_next = {type_class_shift_next[23:0], b};
        end else if (field_byte_index_next < TTL_END) begin
          ttl_shift_next = {ttl_shift_next[23:0], b};
        end else if (field_byte_index_next < LEN_END) begin
          length_shift_next = {length_shift_next[7:0], b};
        end else begin
          data_shift_next = {data_shift_next[23:0], b};
        end
        field_byte_index_next = idx_inc;
        if (idx_inc >= RFIELD_BYTES) begin
          records_left_next = records_left_next - 16'd1;
          done = (questions_left_next == '0) && (records_left_next == '0);
          has_result          = 1'b1;
          result.kind         = KIND_RECORD;
          result.rr_type      = type_class_shift_next[31:16];
          result.rr_class     = type_class_shift_next[15:0];
          result.time_to_live = ttl_shift_next;
          result.data_length  = length_shift_next;
          result.record_data  = data_shift_next;
          result.message_done = done;
          start_now           = 1'b1;
        end
      end
      PH_IDLE: begin
        parse_phase_next = PH_IDLE;
      end
      default: begin
        parse_phase_next = PH_IDLE;
      end
    endcase

    if (start_now) begin
      label_bytes_left_next = '0;
      first_label_flag_next = 1'b1;
      field_byte_index_next = '0;
      type_class_shift_next = '0;
      ttl_shift_next        = '0;
      length_shift_next     = '0;
      data_shift_next       = '0;
      parse_phase_next = ((questions_left_next != '0) || (records_left_next != '0)) ?
                         PH_NAME : PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HEADER;
      header_bytes_seen <= '0;
      label_bytes_left  <= '0;
      first_label_flag  <= 1'b1;
      field_byte_index  <= '0;
      questions_left    <= '0;
      records_left      <= '0;
      type_class_shift  <= '0;
      ttl_shift         <= '0;
      length_shift      <= '0;
      data_shift        <= '0;
    end else if (advance) begin
      parse_phase       <= parse_phase_next;
      header_bytes_seen <= header_bytes_seen_next;
      label_bytes_left  <= label_bytes_left_next;
      first_label_flag  <= first_label_flag_next;
      field_byte_index  <= field_byte_index_next;
      questions_left    <= questions_left_next;
      records_left      <= records_left_next;
      type_class_shift  <= type_class_shift_next;
      ttl_shift         <= ttl_shift_next;
      length_shift      <= length_shift_next;
      data_shift        <= data_shift_next;
    end
  end

endmodule
`default_nettype wire

>>> design/dqrp_out_stage.sv
// Result register presenting one finished item to the receiver.
`default_nettype none
module dqrp_out_stage
  import dqrp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result_in,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      result_q
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule
`default_nettype wire

>>> design/dns_question_record_parser.sv
// Top level of the DNS question and resource record parser.
//
// Input channel: one message byte per item (data_byte, message_start and the
// question and record counts, sampled with message_start), in_valid/in_ready.
// Output channel: one result per item at most (name character, question
// complete or record complete), out_valid/out_ready, each field on its port.
// Path: an accepted byte is held in the input register, and its result, if
// any, is loaded into the result register and shown at out_valid.
// Throughput: one byte per cycle while the receiver keeps out_ready high; the
// combinational parse step between the two registers sets this figure.
// Bytes with no result (header, first label length byte, name-end zero, field
// bytes before the last, idle bytes) pass through without touching the output.
// Reset: parser returns to header skip with zero counts, both registers empty.
// Receiver stall: the result register holds; a byte with no result still
// advances, and the next byte that yields a result waits in the input
// register, which then drops in_ready until the result register frees.
`default_nettype none
module dns_question_record_parser
  import dqrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        message_start,
  input  wire logic [15:0] question_count,
  input  wire logic [15:0] record_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       name_char,
  output logic [15:0]      rr_type,
  output logic [15:0]      rr_class,
  output logic [31:0]      time_to_live,
  output logic [15:0]      data_length,
  output logic [31:0]      record_data,
  output logic             message_done
);

  item_t   item_in;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    has_result;
  logic    out_free;
  result_t step_result;
  result_t result_q;

  assign item_in.data_byte      = data_byte;
  assign item_in.message_start  = message_start;
  assign item_in.question_count = question_count;
  assign item_in.record_count   = record_count;

  assign advance = stage_valid && (out_free || !has_result);

  dqrp_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_in     (item_in),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  dqrp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .item       (stage_item),
    .advance    (advance),
    .has_result (has_result),
    .result     (step_result)
  );

  dqrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .result_in (step_result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign result_kind  = result_q.kind;
  assign name_char    = result_q.name_char;
  assign rr_type      = result_q.rr_type;
  assign rr_class     = result_q.rr_class;
  assign time_to_live = result_q.time_to_live;
  assign data_length  = result_q.data_length;
  assign record_data  = result_q.record_data;
  assign message_done = result_q.message_done;

endmodule
`default_nettype wire

>>> design/dqrp_checker.sv
// Port-level checks for the parser, bound to the top level.
`default_nettype none
module dqrp_checker
  import dqrp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  result_kind,
  input wire logic [7:0]  name_char,
  input wire logic [31:0] time_to_live,
  input wire logic [15:0] data_length,
  input wire logic [31:0] record_data,
  input wire logic        message_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(name_char)
      && $stable(message_done))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_char_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_CHAR) |-> !message_done)
    else $error("name character flagged as message end");

  a_question_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_QUESTION) |->
      (time_to_live == '0) && (data_length == '0) && (record_data == '0))
    else $error("question carries record fields");

endmodule

bind dns_question_record_parser dqrp_checker u_dqrp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .name_char    (name_char),
  .time_to_live (time_to_live),
  .data_length  (data_length),
  .record_data  (record_data),
  .message_done (message_done)
);
`default_nettype wire

>>> tb/sv/dns_question_record_parser_test.sv
// Testbench for the DNS question and record parser: directed and random messages, scored.
`default_nettype none
module dns_question_record_parser_test;
  import dqrp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_style_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        message_start;
  logic [15:0] question_count;
  logic [15:0] record_count;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [7:0]  name_char;
  logic [15:0] rr_type;
  logic [15:0] rr_class;
  logic [31:0] time_to_live;
  logic [15:0] data_length;
  logic [31:0] record_data;
  logic        message_done;

  dns_question_record_parser u_top (.*);

  // parser state as predicted from the accepted bytes
  phase_t      cur_phase;
  logic [3:0]  hdr_count;
  logic [7:0]  label_left;
  logic        first_label;
  logic [3:0]  field_idx;
  logic [15:0] questions_due;
  logic [15:0] records_due;
  logic [31:0] type_class_acc;
  logic [31:0] ttl_acc;
  logic [15:0] length_acc;
  logic [31:0] rdata_acc;

  result_t     pending_results[$];
  result_t     due_result;
  logic [7:0]  msg_bytes[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          ready_tick = 0;
  int          hold_off_left;
  rx_style_t   stall_style;
  int          sender_gap_max;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void next_entry();
    label_left     = '0;
    first_label    = 1'b1;
    field_idx      = '0;
    type_class_acc = '0;
    ttl_acc        = '0;
    length_acc     = '0;
    rdata_acc      = '0;
    cur_phase      = (questions_due != '0 || records_due != '0) ? PH_NAME : PH_IDLE;
  endfunction

  function automatic void parse_message_byte(input logic [7:0] b, input logic st,
                                             input logic [15:0] qc, input logic [15:0] rc);
    result_t r;
    r = '0;
    if (st) begin
      questions_due = qc;
      records_due   = rc;
      hdr_count     = '0;
      if (HEADER_BYTES == 0) next_entry();
      else cur_phase = PH_HEADER;
    end
    case (cur_phase)
      PH_HEADER: begin
        hdr_count = hdr_count + 4'd1;
        if (32'(hdr_count) >= HEADER_BYTES) next_entry();
      end
      PH_NAME: begin
        if (label_left != '0) begin
          label_left  = label_left - 8'd1;
          r.kind      = KIND_CHAR;
          r.name_char = b;
          pending_results.push_back(r);
        end else if (b == 8'd0) begin
          field_idx = '0;
          cur_phase = (questions_due != '0) ? PH_QFIELDS : PH_RFIELDS;
        end else begin
          label_left = b;
          if (first_label) begin
            first_label = 1'b0;
          end else begin
            r.kind      = KIND_CHAR;
            r.name_char = DOT_CHAR;
            pending_results.push_back(r);
          end
        end
      end
      PH_QFIELDS: begin
        type_class_acc = {type_class_acc[23:0], b};
        field_idx = field_idx + 4'd1;
        if (field_idx >= QFIELD_BYTES) begin
          questions_due  = questions_due - 16'd1;
          r.kind         = KIND_QUESTION;
          r.rr_type      = type_class_acc[31:16];
          r.rr_class     = type_class_acc[15:0];
          r.message_done = (questions_due == '0 && records_due == '0);
          pending_results.push_back(r);
          next_entry();
        end
      end
      PH_RFIELDS: begin
        if (field_idx < QFIELD_BYTES) type_class_acc = {type_class_acc[23:0], b};
        else if (field_idx < TTL_END) ttl_acc = {ttl_acc[23:0], b};
        else if (field_idx < LEN_END) length_acc = {length_acc[7:0], b};
        else rdata_acc = {rdata_acc[23:0], b};
        field_idx = field_idx + 4'd1;
        if (field_idx >= RFIELD_BYTES) begin
          records_due    = records_due - 16'd1;
          r.kind         = KIND_RECORD;
          r.rr_type      = type_class_acc[31:16];
          r.rr_class     = type_class_acc[15:0];
          r.time_to_live = ttl_acc;
          r.data_length  = length_acc;
          r.record_data  = rdata_acc;
          r.message_done = (questions_due == '0 && records_due == '0);
          pending_results.push_back(r);
          next_entry();
        end
      end
      default: cur_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_phase     = PH_HEADER;
      hdr_count     = '0;
      questions_due = '0;
      records_due   = '0;
      next_entry();
      cur_phase     = PH_HEADER;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result_kind: expected none, got %0h", result_kind);
          mismatch_count++;
        end else begin
          due_result = pending_results.pop_front();
          check_field("result_kind", 32'(due_result.kind), 32'(result_kind));
          check_field("name_char", 32'(due_result.name_char), 32'(name_char));
          check_field("rr_type", 32'(due_result.rr_type), 32'(rr_type));
          check_field("rr_class", 32'(due_result.rr_class), 32'(rr_class));
          check_field("time_to_live", due_result.time_to_live, time_to_live);
          check_field("data_length", 32'(due_result.data_length), 32'(data_length));
          check_field("record_data", due_result.record_data, record_data);
          check_field("message_done", 32'(due_result.message_done), 32'(message_done));
        end
      end
      if (in_valid && in_ready)
        parse_message_byte(data_byte, message_start, question_count, record_count);
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      ready_tick++;
      if (hold_off_left != 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        case (stall_style)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ready <= ((ready_tick % 8) >= 3);
          default:    out_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st,
                           input logic [15:0] qc, input logic [15:0] rc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_byte      <= b;
    message_start  <= st;
    question_count <= qc;
    record_count   <= rc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void begin_message();
    msg_bytes.delete();
    repeat (HEADER_BYTES) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_random_bytes(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_name(input int labels);
    int len;
    repeat (labels) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(192, 255) : $urandom_range(1, 12);
      msg_bytes.push_back(8'(len));
      add_random_bytes(len);
    end
    msg_bytes.push_back(8'd0);
  endfunction

  task automatic send_message(input logic [15:0] qc, input logic [15:0] rc, input int upto);
    for (int i = 0; i < upto && i < msg_bytes.size(); i++) begin
      if (i == 0) send_byte(msg_bytes[i], 1'b1, qc, rc);
      else send_byte(msg_bytes[i], 1'b0, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_stray_bytes();
    stall_style    = RX_ALWAYS;
    sender_gap_max = 0;
    repeat (20) send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
    wait_drained();
  endtask

  task automatic test_empty_message();
    begin_message();
    add_random_bytes(6);
    send_message(16'd0, 16'd0, msg_bytes.size());
    wait_drained();
  endtask

  task automatic test_question_name();
    stall_style = RX_RANDOM;
    begin_message();
    msg_bytes.push_back(8'd3);
    msg_bytes.push_back(8'h61);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'd1);
    msg_bytes.push_back(DOT_CHAR);
    msg_bytes.push_back(8'd0);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h00);
    send_message(16'd1, 16'd0, msg_bytes.size());
    wait_drained();
  endtask

  task automatic test_record_fields();
    stall_style    = RX_PATTERN;
    sender_gap_max = 3;
    begin_message();
    msg_bytes.push_back(8'd0);
    repeat (14) msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'd2);
    msg_bytes.push_back(8'h78);
    msg_bytes.push_back(8'h79);
    msg_bytes.push_back(8'd0);
    repeat (14) msg_bytes.push_back(8'h00);
    send_message(16'd0, 16'd2, msg_bytes.size());
    wait_drained();
  endtask

  task automatic test_restart_mid_message();
    stall_style = RX_RANDOM;
    begin_message();
    msg_bytes.push_back(8'd5);
    msg_bytes.push_back(8'h41);
    msg_bytes.push_back(8'h42);
    send_message(16'hFFFF, 16'hFFFF, msg_bytes.size());
    begin_message();
    msg_bytes.push_back(8'd1);
    msg_bytes.push_back(8'h7A);
    msg_bytes.push_back(8'd0);
    add_random_bytes(14);
    send_message(16'd0, 16'd1, msg_bytes.size());
    // drop: bytes after the last record are ignored
    repeat (4) send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
    wait_drained();
  endtask

  task automatic test_receiver_hold_off();
    stall_style    = RX_ALWAYS;
    sender_gap_max = 0;
    hold_off_left  = 400;
    begin_message();
    msg_bytes.push_back(8'd255);
    add_random_bytes(255);
    msg_bytes.push_back(8'd192);
    add_random_bytes(192);
    msg_bytes.push_back(8'd0);
    add_random_bytes(4);
    msg_bytes.push_back(8'd3);
    add_random_bytes(3);
    msg_bytes.push_back(8'd0);
    add_random_bytes(14);
    send_message(16'd1, 16'd1, msg_bytes.size());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    int nq;
    int nr;
    int upto;
    sent = 0;
    while (sent < 400) begin
      stall_style    = rx_style_t'($urandom_range(0, 3));
      sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      begin_message();
      if (pick == 0) begin
        add_random_bytes($urandom_range(4, 60));
        send_message(16'($urandom), 16'($urandom), $urandom_range(1, msg_bytes.size()));
      end else begin
        nq = $urandom_range(0, 3);
        nr = $urandom_range(0, 3);
        repeat (nq) begin
          add_name($urandom_range(0, 3));
          add_random_bytes(4);
        end
        repeat (nr) begin
          add_name($urandom_range(0, 3));
          add_random_bytes(14);
        end
        upto = (pick == 1) ? $urandom_range(1, msg_bytes.size()) : msg_bytes.size();
        send_message(16'(nq), 16'(nr), upto);
        sent += upto;
        if (pick == 2)
          repeat ($urandom_range(1, 5))
            send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = '0;
    message_start  = 1'b0;
    question_count = '0;
    record_count   = '0;
    hold_off_left  = 0;
    stall_style    = RX_ALWAYS;
    sender_gap_max = 0;
    burst_left     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_stray_bytes();
    test_empty_message();
    test_question_name();
    test_record_fields();
    test_restart_mid_message();
    test_receiver_hold_off();
    test_random_traffic();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
design/dqrp_pkg.sv
design/dqrp_in_stage.sv
design/dqrp_step.sv
design/dqrp_out_stage.sv
design/dns_question_record_parser.sv
design/dqrp_checker.sv
tb/sv/dns_question_record_parser_test.sv
